// File: hdl/pied_pkg.sv
// Package for the power-iteration eigen-decomposition block.
// Holds the sequencer state type, status and register codes and the Q format.
// No dependencies.
package pied_pkg;

  // Fraction bits of every Q-format value
  localparam int FRAC_BITS = 24;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MV,
    ST_DOT,
    ST_LDIV,
    ST_SQRT,
    ST_NDIV,
    ST_DEFL,
    ST_OUT
  } state_e;

  // Which dot product is being accumulated
  typedef enum logic [1:0] {
    DOT_NUM,
    DOT_DEN,
    DOT_SQ
  } dot_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_SAT  = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SIZE = 1'b0,
    CFG_ITER = 1'b1
  } cfg_e;

endpackage

// File: hdl/power_iteration_eigen_deflation.sv
// Run: the last entry's transfer starts the run; each eigenpair is followed by n
//   result transfers, n being the order in use.
// Throughput: one matrix entry per cycle while loading; no entry is taken during
//   a run. A shared multiplier and a bit-serial divider and root do the work.
// Reset: asynchronous, active low; registers return to size 7 and 12 iterations.
// Depends on pied_pkg.
module power_iteration_eigen_deflation #(
  parameter int MAX_ORDER  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] entry_value_i,
  input  logic               last_entry_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         pair_index_o,
  output logic [2:0]         element_index_o,
  output logic signed [31:0] eigen_value_o,
  output logic signed [31:0] vector_element_o,
  output logic [1:0]         status_o,
  output logic               last_result_o
);

  localparam int W    = DATA_WIDTH;
  localparam int PW   = 2 * W;
  localparam int FB   = pied_pkg::FRAC_BITS;
  localparam int ACCW = W + $clog2(MAX_ORDER) + 1;
  localparam int IW   = $clog2(MAX_ORDER);
  localparam int NW   = $clog2(MAX_ORDER + 1);
  localparam int AW   = $clog2(MAX_ORDER * MAX_ORDER);
  localparam int DQ   = W + FB;
  localparam int P    = (W + FB + 1) / 2;
  localparam int SB   = 2 * P;
  localparam int RW   = P + 2;
  localparam int CNW  = $clog2(DQ + 1);
  localparam int LW   = (W > 32) ? W : 32;
  localparam int EW   = (W > 32) ? W : 33;
  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = (W > FB + 1) ? W'(1 << FB) : MAXW;

  // saturate a wide value to W bits; msb of result flags saturation
  function automatic logic [W:0] clipw(input logic signed [PW-1:0] v);
    logic fits;
    fits = (&v[PW-1:W-1]) | (~|v[PW-1:W-1]);
    return {~fits, fits ? v[W-1:0] : (v[PW-1] ? MINW : MAXW)};
  endfunction

  // floor of product over 2^24, saturated
  function automatic logic [W:0] satq(input logic signed [PW-1:0] p);
    return clipw(p >>> FB);
  endfunction

  // saturate to the 32-bit result field
  function automatic logic [32:0] to32(input logic signed [W-1:0] v);
    logic signed [EW-1:0] e;
    logic fits;
    e = EW'(v);
    fits = (&e[EW-1:31]) | (~|e[EW-1:31]);
    return {~fits, fits ? e[31:0] : (e[EW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
  endfunction

  // state and control
  pied_pkg::state_e  state_q, state_d;
  pied_pkg::dot_e    dsel_q, dsel_d;
  pied_pkg::status_e status_q, status_d;
  logic [2:0]     ph_q, ph_d;
  logic [IW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [5:0]     it_q, it_d;
  logic [NW-1:0]  lr_q, lr_d;
  logic [IW-1:0]  lc_q, lc_d;
  logic [3:0]     size_q;
  logic [5:0]     itc_q;
  logic [CNW-1:0] cnt_q, cnt_d;

  // datapath
  logic signed [W-1:0]    x_q [MAX_ORDER];
  logic signed [W-1:0]    x_d [MAX_ORDER];
  logic signed [W-1:0]    p_q [MAX_ORDER];
  logic signed [W-1:0]    p_d [MAX_ORDER];
  logic signed [W-1:0]    lam_q, lam_d, num_q, num_d, den_q, den_d, sq_q, sq_d;
  logic signed [W-1:0]    opa_q, opa_d;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic signed [ACCW-1:0] acc_q, acc_d, acc_n;
  logic                   sat_q, sat_d, zero_q, zero_d;

  // matrix store
  logic signed [W-1:0] mem [MAX_ORDER*MAX_ORDER];
  logic signed [W-1:0] rd_q, wdata;
  logic [AW-1:0]       raddr, waddr;
  logic                mem_we;

  // shared multiplier
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] mul_res;

  // divider
  logic [DQ-1:0]       dvd_q, quo_q;
  logic [W-1:0]        rem_q, ud_q;
  logic                dneg_q;
  logic                div_go, div_step;
  logic signed [W-1:0] div_num;
  logic signed [W:0]   div_den, dn_ext;
  logic [W-1:0]        div_un, div_ud;
  logic [W:0]          d_rs;
  logic                d_ge, d_big;
  logic [W-1:0]        d_mag;
  logic signed [W-1:0] dres;

  // square root
  logic [SB-1:0]       sv_q;
  logic [RW-1:0]       srem_q, s_rs, s_tr;
  logic [P-1:0]        sroot_q;
  logic                sq_go, sq_step, s_ge;
  logic signed [W-1:0] sq_in;

  // misc
  logic [NW-1:0]       n;
  logic [IW-1:0]       nm1, i1, x_idx, p_idx;
  logic                il, jl, more, in_fire, out_fire, wide;
  logic [6:0]          it_next;
  logic signed [W-1:0] xr, pr, load_val, t1, t2;
  logic signed [LW-1:0] le;
  logic                f1, f2;
  logic [32:0]         lam32, vec32;

  // order in use, clamped
  always_comb begin
    if (size_q < 4'd2) begin
      n = NW'(2);
    end else if (int'(size_q) > MAX_ORDER) begin
      n = NW'(MAX_ORDER);
    end else begin
      n = NW'(size_q);
    end
  end

  assign nm1      = IW'(n - 1'b1);
  assign il       = (i_q == nm1);
  assign jl       = (j_q == nm1);
  assign it_next  = 7'(it_q) + 7'd1;
  assign more     = (it_next < 7'(itc_q));
  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;
  assign i1       = (i_q == IW'(MAX_ORDER - 1)) ? '0 : i_q + 1'b1;

  // vector read ports, one address each
  assign x_idx = ((state_q == pied_pkg::ST_MV) ||
                  (state_q == pied_pkg::ST_DEFL && ph_q != 3'd0)) ? j_q : i_q;
  assign p_idx = (state_q == pied_pkg::ST_NDIV) ? i1 : i_q;
  assign xr    = x_q[x_idx];
  assign pr    = p_q[p_idx];

  // entry clipped to the working width
  always_comb begin
    le       = LW'(entry_value_i);
    load_val = ((&le[LW-1:W-1]) | (~|le[LW-1:W-1])) ? le[W-1:0] :
               (le[LW-1] ? MINW : MAXW);
  end

  // matrix addresses
  assign raddr = AW'(int'(i_q) * MAX_ORDER + int'(j_q));
  assign waddr = (state_q == pied_pkg::ST_IDLE) ?
                 AW'(int'(lr_q[IW-1:0]) * MAX_ORDER + int'(lc_q)) : raddr;

  assign mul_res = PW'(mul_a) * PW'(mul_b);

  // divider: operand magnitudes, one quotient bit per step
  always_comb begin
    dn_ext   = (W+1)'(div_num);
    div_un   = dn_ext[W] ? W'(-dn_ext) : dn_ext[W-1:0];
    div_ud   = div_den[W] ? W'(-div_den) : div_den[W-1:0];
    d_rs     = {rem_q, dvd_q[DQ-1]};
    d_ge     = (d_rs >= {1'b0, ud_q});
    d_big    = |quo_q[DQ-1:W-1];
    d_mag    = quo_q[W-1:0];
    if (d_big) begin
      dres = dneg_q ? MINW : MAXW;
    end else begin
      dres = dneg_q ? -$signed(d_mag) : $signed(d_mag);
    end
  end

  // square root: one root bit per step
  always_comb begin
    s_rs = {srem_q[RW-3:0], sv_q[SB-1:SB-2]};
    s_tr = {sroot_q, 2'b01};
    s_ge = (s_rs >= s_tr);
  end

  // pair is wide for the result field
  always_comb begin
    wide = to32(lam_q) >> 32 != 33'd0;
    for (int e = 0; e < MAX_ORDER; e++) begin
      if (NW'(e) < n && to32(x_q[e]) >> 32 != 33'd0) begin
        wide = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pied_pkg::ST_IDLE: if (in_fire && last_entry_i) state_d = pied_pkg::ST_INIT;
      pied_pkg::ST_INIT: state_d = (itc_q == 6'd0) ? pied_pkg::ST_DEFL : pied_pkg::ST_MV;
      pied_pkg::ST_MV:   if (ph_q == 3'd2 && il && jl) state_d = pied_pkg::ST_DOT;
      pied_pkg::ST_DOT: begin
        if (ph_q == 3'd2 && il && dsel_q == pied_pkg::DOT_SQ) begin
          state_d = (den_q == '0) ? pied_pkg::ST_SQRT : pied_pkg::ST_LDIV;
        end
      end
      pied_pkg::ST_LDIV: if (cnt_q == '0) state_d = pied_pkg::ST_SQRT;
      pied_pkg::ST_SQRT: begin
        if (cnt_q == '0) begin
          if (sroot_q != '0) begin
            state_d = pied_pkg::ST_NDIV;
          end else begin
            state_d = more ? pied_pkg::ST_MV : pied_pkg::ST_DEFL;
          end
        end
      end
      pied_pkg::ST_NDIV: begin
        if (cnt_q == '0 && il) state_d = more ? pied_pkg::ST_MV : pied_pkg::ST_DEFL;
      end
      pied_pkg::ST_DEFL: if (ph_q == 3'd4 && il && jl) state_d = pied_pkg::ST_OUT;
      pied_pkg::ST_OUT: begin
        if (out_fire && il) begin
          state_d = (k_q == nm1) ? pied_pkg::ST_IDLE : pied_pkg::ST_INIT;
        end
      end
      default: state_d = pied_pkg::ST_IDLE;
    endcase
  end

  // handshake and result fields
  always_comb begin
    in_ready_o       = (state_q == pied_pkg::ST_IDLE);
    out_valid_o      = (state_q == pied_pkg::ST_OUT);
    lam32            = to32(lam_q);
    vec32            = to32(xr);
    pair_index_o     = 3'(k_q);
    element_index_o  = 3'(i_q);
    eigen_value_o    = lam32[31:0];
    vector_element_o = vec32[31:0];
    status_o         = status_q;
    last_result_o    = (k_q == nm1) && il;
  end

  // datapath sequencing
  always_comb begin
    dsel_d = dsel_q;  status_d = status_q;  ph_d = ph_q;
    i_d = i_q;  j_d = j_q;  k_d = k_q;  it_d = it_q;  lr_d = lr_q;  lc_d = lc_q;
    x_d = x_q;  p_d = p_q;  lam_d = lam_q;  num_d = num_q;  den_d = den_q;  sq_d = sq_q;
    opa_d = opa_q;  prod_d = prod_q;  acc_d = acc_q;  sat_d = sat_q;  zero_d = zero_q;
    mem_we = 1'b0;  wdata = load_val;
    mul_a = xr;  mul_b = xr;
    div_go = 1'b0;  div_num = num_q;  div_den = (W+1)'(den_q);
    sq_go = 1'b0;  sq_in = sq_q;
    div_step = 1'b0;  sq_step = 1'b0;
    {f1, t1} = satq(prod_q);
    acc_n = acc_q + ACCW'(t1);
    {f2, t2} = clipw(PW'(acc_n));
    unique case (state_q)
      pied_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (lr_q < n) begin
            mem_we = 1'b1;
            if (lc_q == nm1) begin
              lc_d = '0;
              lr_d = lr_q + 1'b1;
            end else begin
              lc_d = lc_q + 1'b1;
            end
          end
          if (last_entry_i) begin
            lr_d = '0;
            lc_d = '0;
            k_d  = '0;
          end
        end
      end
      pied_pkg::ST_INIT: begin
        for (int e = 0; e < MAX_ORDER; e++) x_d[e] = ONE;
        lam_d = '0;  sat_d = 1'b0;  zero_d = 1'b0;  it_d = '0;
        i_d = '0;  j_d = '0;  ph_d = 3'd0;  acc_d = '0;
      end
      // Ax, one multiply-accumulate per pass through the read, multiply and accumulate phases
      pied_pkg::ST_MV: begin
        case (ph_q)
          3'd0: ph_d = 3'd1;
          3'd1: begin
            mul_a  = rd_q;
            prod_d = mul_res;
            ph_d   = 3'd2;
          end
          default: begin
            sat_d = sat_q | f1;
            ph_d  = 3'd0;
            if (jl) begin
              p_d[i_q] = t2;
              sat_d    = sat_q | f1 | f2;
              acc_d    = '0;
              j_d      = '0;
              if (il) begin
                i_d    = '0;
                dsel_d = pied_pkg::DOT_NUM;
                ph_d   = 3'd1;
              end else begin
                i_d = i_q + 1'b1;
              end
            end else begin
              acc_d = acc_n;
              j_d   = j_q + 1'b1;
            end
          end
        endcase
      end
      // Ax.x, x.x and Ax.Ax in turn
      pied_pkg::ST_DOT: begin
        if (ph_q == 3'd2) begin
          sat_d = sat_q | f1;
          ph_d  = 3'd1;
          if (il) begin
            sat_d = sat_q | f1 | f2;
            acc_d = '0;
            i_d   = '0;
            case (dsel_q)
              pied_pkg::DOT_NUM: begin
                num_d  = t2;
                dsel_d = pied_pkg::DOT_DEN;
              end
              pied_pkg::DOT_DEN: begin
                den_d  = t2;
                dsel_d = pied_pkg::DOT_SQ;
              end
              default: begin
                sq_d = t2;
                if (den_q == '0) begin
                  lam_d  = '0;
                  zero_d = 1'b1;
                  sq_go  = 1'b1;
                  sq_in  = t2;
                end else begin
                  div_go = 1'b1;
                end
              end
            endcase
          end else begin
            acc_d = acc_n;
            i_d   = i_q + 1'b1;
          end
        end else begin
          case (dsel_q)
            pied_pkg::DOT_NUM: mul_a = pr;
            pied_pkg::DOT_DEN: mul_a = xr;
            default: begin
              mul_a = pr;
              mul_b = pr;
            end
          endcase
          prod_d = mul_res;
          ph_d   = 3'd2;
        end
      end
      // Rayleigh quotient
      pied_pkg::ST_LDIV: begin
        if (cnt_q != '0) begin
          div_step = 1'b1;
        end else begin
          lam_d = dres;
          sat_d = sat_q | d_big;
          sq_go = 1'b1;
        end
      end
      // Euclidean norm
      pied_pkg::ST_SQRT: begin
        if (cnt_q != '0) begin
          sq_step = 1'b1;
        end else begin
          i_d = '0;
          if (sroot_q != '0) begin
            div_go  = 1'b1;
            div_num = pr;
            div_den = (W+1)'(sroot_q);
          end else begin
            zero_d = 1'b1;
            it_d = it_q + 1'b1;  j_d = '0;  ph_d = 3'd0;  acc_d = '0;
          end
        end
      end
      // normalise one element per division
      pied_pkg::ST_NDIV: begin
        if (cnt_q != '0) begin
          div_step = 1'b1;
        end else begin
          x_d[i_q] = dres;
          sat_d    = sat_q | d_big;
          if (il) begin
            i_d = '0;  it_d = it_q + 1'b1;  j_d = '0;  ph_d = 3'd0;  acc_d = '0;
          end else begin
            i_d     = i1;
            div_go  = 1'b1;
            div_num = pr;
            div_den = (W+1)'(sroot_q);
          end
        end
      end
      // A -= lambda * x_i * x_j, one entry per pass through phases 0 to 4
      pied_pkg::ST_DEFL: begin
        case (ph_q)
          3'd0: begin
            opa_d = xr;
            ph_d  = 3'd1;
          end
          3'd1: begin
            mul_a  = opa_q;
            prod_d = mul_res;
            ph_d   = 3'd2;
          end
          3'd2: begin
            opa_d = t1;
            sat_d = sat_q | f1;
            ph_d  = 3'd3;
          end
          3'd3: begin
            mul_a  = lam_q;
            mul_b  = opa_q;
            prod_d = mul_res;
            ph_d   = 3'd4;
          end
          default: begin
            {f2, wdata} = clipw(PW'(rd_q) - PW'(t1));
            mem_we = 1'b1;
            sat_d  = sat_q | f1 | f2;
            ph_d   = 3'd0;
            if (jl) begin
              j_d = '0;
              if (il) begin
                i_d = '0;
                if (zero_q) begin
                  status_d = pied_pkg::STATUS_ZERO;
                end else if (sat_q | f1 | f2 | wide) begin
                  status_d = pied_pkg::STATUS_SAT;
                end else begin
                  status_d = pied_pkg::STATUS_OK;
                end
              end else begin
                i_d = i_q + 1'b1;
              end
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end
      pied_pkg::ST_OUT: begin
        if (out_fire) begin
          if (il) begin
            i_d = '0;
            k_d = k_q + 1'b1;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // shared step counter
  always_comb begin
    if (div_go) begin
      cnt_d = CNW'(DQ);
    end else if (sq_go) begin
      cnt_d = CNW'(P);
    end else if (div_step || sq_step) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pied_pkg::ST_IDLE;
      dsel_q  <= pied_pkg::DOT_NUM;
      ph_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      it_q    <= '0;
      lr_q    <= '0;
      lc_q    <= '0;
      cnt_q   <= '0;
      size_q  <= 4'd7;
      itc_q   <= 6'd12;
    end else begin
      state_q <= state_d;
      dsel_q  <= dsel_d;
      ph_q    <= ph_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      it_q    <= it_d;
      lr_q    <= lr_d;
      lc_q    <= lc_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_index_i == pied_pkg::CFG_SIZE) begin
          size_q <= cfg_data_i[3:0];
        end else begin
          itc_q <= cfg_data_i;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    p_q      <= p_d;
    lam_q    <= lam_d;
    num_q    <= num_d;
    den_q    <= den_d;
    sq_q     <= sq_d;
    opa_q    <= opa_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    sat_q    <= sat_d;
    zero_q   <= zero_d;
    status_q <= status_d;
    // divider
    if (div_go) begin
      dvd_q  <= DQ'(div_un) << FB;
      rem_q  <= '0;
      quo_q  <= '0;
      ud_q   <= div_ud;
      dneg_q <= div_num[W-1] ^ div_den[W];
    end else if (div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= d_ge ? W'(d_rs - {1'b0, ud_q}) : d_rs[W-1:0];
      quo_q <= {quo_q[DQ-2:0], d_ge};
    end
    // square root
    if (sq_go) begin
      sv_q    <= SB'($unsigned(sq_in)) << FB;
      srem_q  <= '0;
      sroot_q <= '0;
    end else if (sq_step) begin
      sv_q    <= sv_q << 2;
      srem_q  <= s_ge ? s_rs - s_tr : s_rs;
      sroot_q <= {sroot_q[P-2:0], s_ge};
    end
  end

  // matrix store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

`ifndef NO_ASSERTIONS
  // loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while results pending");

  // the final entry starts a run
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_entry_i) |=> (state_q == pied_pkg::ST_INIT))
    else $error("run did not start after last entry");

  // the final result returns the block to loading
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_result_o) |=> in_ready_o)
    else $error("block not idle after last result");

  // a division in progress is not abandoned
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pied_pkg::ST_LDIV || state_q == pied_pkg::ST_NDIV) && cnt_q != '0)
    |=> (state_q == $past(state_q)))
    else $error("division left before completion");
`endif

endmodule
